@@ design/ilt_pkg.sv @@
// Shared constants, codes and types of the indentation level tracker.
package ilt_pkg;

  localparam int MAX_LEVELS  = 128;
  localparam int COLUMN_BITS = 16;
  localparam int LVL_W       = $clog2(MAX_LEVELS);

  localparam logic [COLUMN_BITS-1:0] COL_MAX = '1;
  localparam logic [LVL_W-1:0]       LVL_TOP = LVL_W'(MAX_LEVELS - 1);

  localparam logic [2:0] TAB_SHIFT_RST = 3'd3;

  localparam logic [7:0] CHR_NEWLINE = 8'd10;
  localparam logic [7:0] CHR_TAB     = 8'd9;
  localparam logic [7:0] CHR_SPACE   = 8'd32;
  localparam logic [7:0] CHR_DEL     = 8'd127;

  localparam logic [1:0] EVT_NONE   = 2'd0;
  localparam logic [1:0] EVT_SAME   = 2'd1;
  localparam logic [1:0] EVT_INDENT = 2'd2;
  localparam logic [1:0] EVT_DEDENT = 2'd3;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_DEEP     = 2'd1;
  localparam logic [1:0] ERR_MISMATCH = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } stk_ctrl_t;

endpackage

@@ design/ilt_cell.sv @@
// One stack cell: takes its upper neighbor on push, its lower neighbor on pop.
module ilt_cell import ilt_pkg::*; (
  input  logic                   clk_i,
  input  stk_ctrl_t              ctrl_i,
  input  logic [COLUMN_BITS-1:0] above_i,
  input  logic [COLUMN_BITS-1:0] below_i,
  output logic [COLUMN_BITS-1:0] val_o
);

  logic [COLUMN_BITS-1:0] val_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      val_q <= above_i;
    end else if (ctrl_i.pop) begin
      val_q <= below_i;
    end
  end

  assign val_o = val_q;

endmodule

@@ design/ilt_stack.sv @@
// Column stack: a top register followed by a chain of shifting cells.
module ilt_stack import ilt_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  stk_ctrl_t              ctrl_i,
  input  logic [COLUMN_BITS-1:0] push_col_i,
  output logic [COLUMN_BITS-1:0] top_o,
  output logic [COLUMN_BITS-1:0] next_o
);

  logic [COLUMN_BITS-1:0] top_q;
  logic [COLUMN_BITS-1:0] chain [MAX_LEVELS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
    end else if (ctrl_i.clear) begin
      top_q <= '0;
    end else if (ctrl_i.push) begin
      top_q <= push_col_i;
    end else if (ctrl_i.pop) begin
      top_q <= chain[1];
    end
  end

  assign chain[0] = top_q;

  for (genvar i = 1; i < MAX_LEVELS; i++) begin : g_cell
    logic [COLUMN_BITS-1:0] below;
    if (i == MAX_LEVELS - 1) begin : g_last
      assign below = chain[i];
    end else begin : g_mid
      assign below = chain[i+1];
    end
    ilt_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .above_i (chain[i-1]),
      .below_i (below),
      .val_o   (chain[i])
    );
  end

  assign top_o  = top_q;
  assign next_o = chain[1];

endmodule

@@ design/indentation_level_tracker.sv @@
// Indentation level tracker: byte stream in, sanitized bytes and level events out.
//
// Input channel: in_valid_i / in_stall_o with in_byte_i and end_of_file_i; a beat
// moves when valid is high and stall is low. Output channel: res_valid_o /
// res_stall_i with one result beat per input beat, in order.
// Configuration: cfg_valid_i / cfg_ready_o writes tab_shift from cfg_data_i;
// ready is always high, write only while idle.
// Each result is registered in the result register first and moves on to the
// output register once that is free; in_stall_o stays high while a result sits
// in the result register. A byte that closes a dedent holds the input while the
// stack walks one cell per cycle, popping each level and then checking the level
// reached.
// A result register sits between the input and the output register, so a new
// beat is accepted while a finished result waits in the output register.
// When the receiver stalls, both registers fill and in_stall_o rises.
// Reset: level 0, column 0, first line not measured, no error, tab_shift 3,
// no result pending. Errors halt processing until reset.
module indentation_level_tracker import ilt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_file_i,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_valid_o,
  output logic       line_end_o,
  output logic [1:0] level_event_o,
  output logic [6:0] new_level_o,
  output logic [1:0] error_code_o,
  output logic       stopped_o
);

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_e;

  typedef struct packed {
    logic [7:0] obyte;
    logic       ovalid;
    logic       lend;
    logic [1:0] event_code;
    logic [6:0] level;
    logic [1:0] err;
    logic       stopped;
  } res_t;

  state_e                 state_q, state_d;
  logic [LVL_W-1:0]       level_q, level_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;
  logic                   meas_q, meas_d;
  logic                   halt_q, halt_d;
  logic [1:0]             err_q, err_d;
  logic [2:0]             ts_q;
  res_t                   res_q, res_d;
  logic                   res_v_q, res_v_d;
  res_t                   out_q;
  logic                   out_v_q;

  stk_ctrl_t              stk_ctrl;
  logic [COLUMN_BITS-1:0] stk_top, stk_next;

  logic                   accept;
  logic                   out_free;
  logic [7:0]             clean_byte;
  logic [COLUMN_BITS:0]   tab_base;
  logic [COLUMN_BITS+7:0] tab_next;

  ilt_stack u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (stk_ctrl),
    .push_col_i (col_q),
    .top_o      (stk_top),
    .next_o     (stk_next)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE) || res_v_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_v_q || !res_stall_i;

  assign clean_byte = (in_byte_i < CHR_SPACE || in_byte_i >= CHR_DEL) ? CHR_SPACE : in_byte_i;
  assign tab_base   = (COLUMN_BITS+1)'(col_q >> ts_q) + (COLUMN_BITS+1)'(1);
  assign tab_next   = (COLUMN_BITS+8)'(tab_base) << ts_q;

  always_comb begin
    state_d  = state_q;
    level_d  = level_q;
    col_d    = col_q;
    meas_d   = meas_q;
    halt_d   = halt_q;
    err_d    = err_q;
    res_d    = res_q;
    res_v_d  = res_v_q;
    stk_ctrl = '0;

    if (res_v_q && out_free) begin
      res_v_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d.obyte      = '0;
          res_d.ovalid     = 1'b0;
          res_d.lend       = 1'b0;
          res_d.event_code = EVT_NONE;
          res_v_d          = 1'b1;
          if (halt_q) begin
          end else if (end_of_file_i) begin
            stk_ctrl.clear = 1'b1;
            level_d        = '0;
            col_d          = '0;
            meas_d         = 1'b0;
          end else if (in_byte_i == CHR_NEWLINE) begin
            res_d.lend = 1'b1;
            meas_d     = 1'b1;
            col_d      = '0;
          end else if (meas_q && in_byte_i == CHR_SPACE) begin
            col_d = (col_q == COL_MAX) ? col_q : col_q + COLUMN_BITS'(1);
          end else if (meas_q && in_byte_i == CHR_TAB) begin
            col_d = (tab_next > (COLUMN_BITS+8)'(COL_MAX)) ? COL_MAX
                                                           : tab_next[COLUMN_BITS-1:0];
          end else begin
            res_d.obyte  = clean_byte;
            res_d.ovalid = 1'b1;
            if (meas_q) begin
              meas_d = 1'b0;
              if (col_q > stk_top) begin
                if (level_q >= LVL_TOP) begin
                  err_d        = ERR_DEEP;
                  halt_d       = 1'b1;
                  res_d.obyte  = '0;
                  res_d.ovalid = 1'b0;
                end else begin
                  stk_ctrl.push    = 1'b1;
                  level_d          = level_q + LVL_W'(1);
                  res_d.event_code = EVT_INDENT;
                end
              end else if (col_q < stk_top) begin
                res_v_d = 1'b0;
                state_d = ST_POP;
              end else begin
                res_d.event_code = EVT_SAME;
              end
            end
          end
        end
      end
      ST_POP: begin
        if (level_q != '0 && col_q <= stk_next) begin
          stk_ctrl.pop = 1'b1;
          level_d      = level_q - LVL_W'(1);
        end else begin
          state_d = ST_IDLE;
          res_v_d = 1'b1;
          if (col_q != stk_top) begin
            err_d        = ERR_MISMATCH;
            halt_d       = 1'b1;
            res_d.obyte  = '0;
            res_d.ovalid = 1'b0;
          end else begin
            res_d.event_code = EVT_DEDENT;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_d.level   = 7'(level_d);
    res_d.err     = err_d;
    res_d.stopped = halt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      level_q <= '0;
      col_q   <= '0;
      meas_q  <= 1'b0;
      halt_q  <= 1'b0;
      err_q   <= ERR_NONE;
      ts_q    <= TAB_SHIFT_RST;
      res_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      level_q <= level_d;
      col_q   <= col_d;
      meas_q  <= meas_d;
      halt_q  <= halt_d;
      err_q   <= err_d;
      res_v_q <= res_v_d;
      if (cfg_valid_i && cfg_ready_o) begin
        ts_q <= cfg_data_i;
      end
      if (out_free) begin
        out_v_q <= res_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_free && res_v_q) begin
      out_q <= res_q;
    end
  end

  assign res_valid_o   = out_v_q;
  assign out_byte_o    = out_q.obyte;
  assign out_valid_o   = out_q.ovalid;
  assign line_end_o    = out_q.lend;
  assign level_event_o = out_q.event_code;
  assign new_level_o   = out_q.level;
  assign error_code_o  = out_q.err;
  assign stopped_o     = out_q.stopped;

`ifndef NO_ASSERTIONS
  a_pop_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POP) |-> in_stall_o)
    else $error("input accepted while the stack walks");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |=> halt_q)
    else $error("halt cleared without reset");

  a_halt_has_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && stopped_o) |-> (error_code_o != ERR_NONE))
    else $error("stopped result without an error code");

  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LVL_TOP)
    else $error("nesting level beyond stack depth");
`endif

endmodule
